### hw/rtl/ldg_pkg.sv
// Shared types and constants for the line segment dot generator.
package ldg_pkg;

  localparam int COORD_W     = 32;
  localparam int WEIGHT_W    = 18;
  localparam int BRIGHT_W    = 17;
  localparam int DENSITY_W   = 16;
  localparam int CNT_W       = 7;
  localparam int DIV_W       = 32;
  localparam int CFG_DATA_W  = 17;
  localparam int CFG_INDEX_W = 3;
  localparam int MAX_DOTS_DEF = 64;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_DENSITY    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BRIGHTNESS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCALE      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRADIENT   = 3'd4;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] dot_x;
    logic signed [COORD_W-1:0] dot_y;
    logic [WEIGHT_W-1:0]       dot_weight;
    logic                      last_dot;
  } dot_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [CNT_W-1:0] rem;
  } div_rsp_t;

endpackage

### hw/rtl/ldg_mul.sv
// Shared 32 by 32 unsigned multiplier with a registered product.
module ldg_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod
);

  // One product per cycle, available the cycle after the operands.
  always_ff @(posedge clk) begin
    prod <= {32'b0, a} * {32'b0, b};
  end

endmodule

### hw/rtl/ldg_div.sv
// Iterative restoring divider: one quotient bit per cycle, small divisor.
module ldg_div (
  input  logic             clk,
  input  logic             rst,
  input  ldg_pkg::div_req_t req,
  output ldg_pkg::div_rsp_t rsp
);

  logic                     busy;
  logic [4:0]               cnt;
  logic [ldg_pkg::DIV_W-1:0] shreg;
  logic [ldg_pkg::CNT_W:0]  rem;
  logic [ldg_pkg::CNT_W-1:0] divisor;
  logic                     done;
  logic [ldg_pkg::CNT_W:0]  trial;
  logic                     ge;

  // Trial subtraction of the divisor from the shifted partial remainder.
  always_comb begin
    trial = {rem[ldg_pkg::CNT_W-1:0], shreg[ldg_pkg::DIV_W-1]};
    ge    = trial >= {1'b0, divisor};
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'd31;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (req.start) begin
      shreg   <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      rem   <= ge ? (trial - {1'b0, divisor}) : trial;
      shreg <= {shreg[ldg_pkg::DIV_W-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = shreg;
  assign rsp.rem  = rem[ldg_pkg::CNT_W-1:0];

endmodule

### hw/rtl/line_segment_dot_generator.sv
// Top level: sequencer, history, configuration and dot stepping datapath.
// Sequence: multiply steps, a search for the dot count, four divisions on the
// shared divider, then one dot per cycle while the output is not stalled.
// Requests are handled one at a time.
// Density zero gives a single dot at the new point, weighted by the brightness.
// Synchronous reset clears history, the previous end weight and the control state, and loads the default configuration.
module line_segment_dot_generator #(
  parameter int MAX_DOTS = ldg_pkg::MAX_DOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ldg_pkg::point_t                     in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ldg_pkg::dot_t                       out_data,
  input  logic                                cfg_write,
  input  logic [ldg_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ldg_pkg::CFG_DATA_W-1:0]      cfg_data
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ZERO = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_CNT  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [15:0] density;
  logic [16:0] brightness;
  logic [6:0]  limit;
  logic        scale;
  logic        grad;

  // History and segment.
  logic signed [31:0] h0x, h0y, h1x, h1y;
  logic signed [31:0] base_x, base_y;
  logic signed [32:0] dx, dy;
  logic [32:0]        ax, ay;
  logic               big;

  // Dot count arithmetic.
  logic [2:0]  mstep;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [63:0] sqx;
  logic [63:0] s_sum;
  logic [60:0] s61;
  logic [31:0] d2;
  logic [61:0] pl;
  logic [63:0] ptot;
  logic [14:0] pq;
  logic [6:0]  k;
  logic [12:0] ksq;
  logic [6:0]  n;
  logic [6:0]  lim;

  // Division and weights.
  logic [1:0]         div_op;
  logic               div_run;
  logic               div_neg;
  ldg_pkg::div_req_t  div_req;
  ldg_pkg::div_rsp_t  div_rsp;
  logic [31:0]        q_fix;
  logic [6:0]         r_fix;
  logic [16:0]        wt;
  logic [17:0]        prev_end;
  logic [17:0]        w1;
  logic [19:0]        w1c, w2c, tw, dw;
  logic [19:0]        dw_mag;

  // Stepping state.
  logic [31:0] qx, qy, accx, accy;
  logic [17:0] qw, accw;
  logic [6:0]  rx, ry, rw, arx, ary, arw;
  logic [6:0]  idx;
  logic [7:0]  sx, sy, sw;
  logic        cx, cy, cw;
  logic [31:0] accx_n, accy_n;
  logic [17:0] accw_n;
  logic [6:0]  arx_n, ary_n, arw_n;
  logic        slot_free;
  logic        out_load;

  assign in_ready  = (state == ST_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign out_load  = slot_free && ((state == ST_ZERO) || (state == ST_EMIT));

  // Segment magnitudes for the length computation, and the dot limit clamped to 1..MAX_DOTS.
  always_comb begin
    ax  = dx[32] ? 33'(-dx) : 33'(dx);
    ay  = dy[32] ? 33'(-dy) : 33'(dy);
    big = (ax[32:31] != 2'b00) || (ay[32:31] != 2'b00);
    if (limit == 7'd0) begin
      lim = 7'd1;
    end else if (limit > 7'(MAX_DOTS)) begin
      lim = 7'(MAX_DOTS);
    end else begin
      lim = limit;
    end
  end

  // Multiplier operand selection per step.
  always_comb begin
    case (mstep)
      3'd0: begin
        mul_a = ax[31:0];
        mul_b = ax[31:0];
      end
      3'd1: begin
        mul_a = ay[31:0];
        mul_b = ay[31:0];
      end
      3'd2: begin
        mul_a = {16'b0, density};
        mul_b = {16'b0, density};
      end
      3'd4: begin
        mul_a = {2'b0, s61[29:0]};
        mul_b = d2;
      end
      3'd5: begin
        mul_a = {1'b0, s61[60:30]};
        mul_b = d2;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ldg_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Sum of squares and the scaled product taken down to whole units of 2^48.
  always_comb begin
    s_sum = sqx + prod;
    ptot  = {1'b0, prod[32:0], 30'b0} + {2'b0, pl};
    if ((prod[63:33] != '0) || ptot[63]) begin
      pq = '1;
    end else begin
      pq = ptot[62:48];
    end
  end

  // Weights for the run and the operand of each division.
  always_comb begin
    tw  = {2'b0, wt, 1'b0} - {2'b0, prev_end};
    w1c = grad ? {2'b0, prev_end} : {3'b0, wt};
    if (grad && ($signed(tw) >= $signed({3'b0, wt}))) begin
      w2c = tw;
    end else begin
      w2c = {3'b0, wt};
    end
    dw     = w2c - w1c;
    dw_mag = dw[19] ? 20'(-dw) : dw;
    div_req.start   = (state == ST_DIV) && !div_run;
    div_req.divisor = n;
    case (div_op)
      2'd0:    div_req.dividend = {15'b0, brightness};
      2'd1:    div_req.dividend = {12'b0, dw_mag};
      2'd2:    div_req.dividend = ax[31:0];
      default: div_req.dividend = ay[31:0];
    endcase
  end

  ldg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Floor correction of a quotient whose dividend was negative.
  always_comb begin
    if (div_neg) begin
      q_fix = ~div_rsp.quot + {31'b0, (div_rsp.rem == 7'd0)};
      r_fix = (div_rsp.rem == 7'd0) ? 7'd0 : (n - div_rsp.rem);
    end else begin
      q_fix = div_rsp.quot;
      r_fix = div_rsp.rem;
    end
  end

  // Next step of each accumulator: add quotient and remainder, carry once.
  always_comb begin
    sx     = {1'b0, arx} + {1'b0, rx};
    sy     = {1'b0, ary} + {1'b0, ry};
    sw     = {1'b0, arw} + {1'b0, rw};
    cx     = sx >= {1'b0, n};
    cy     = sy >= {1'b0, n};
    cw     = sw >= {1'b0, n};
    arx_n  = cx ? 7'(sx - {1'b0, n}) : sx[6:0];
    ary_n  = cy ? 7'(sy - {1'b0, n}) : sy[6:0];
    arw_n  = cw ? 7'(sw - {1'b0, n}) : sw[6:0];
    accx_n = accx + qx + {31'b0, cx};
    accy_n = accy + qy + {31'b0, cy};
    accw_n = accw + qw + {17'b0, cw};
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      density    <= 16'd256;
      brightness <= 17'd65536;
      limit      <= 7'd64;
      scale      <= 1'b0;
      grad       <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        ldg_pkg::CFG_DENSITY:    density    <= cfg_data[15:0];
        ldg_pkg::CFG_BRIGHTNESS: brightness <= cfg_data;
        ldg_pkg::CFG_LIMIT:      limit      <= cfg_data[6:0];
        ldg_pkg::CFG_SCALE:      scale      <= cfg_data[0];
        ldg_pkg::CFG_GRADIENT:   grad       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      h0x       <= '0;
      h0y       <= '0;
      h1x       <= '0;
      h1y       <= '0;
      prev_end  <= '0;
      div_run   <= 1'b0;
      out_valid <= 1'b0;
      mstep     <= '0;
      div_op    <= '0;
    end else begin
      // The output register is loaded when free, otherwise emptied once taken.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            base_x <= h1x;
            base_y <= h1y;
            dx     <= {h0x[31], h0x} - {h1x[31], h1x};
            dy     <= {h0y[31], h0y} - {h1y[31], h1y};
            h1x    <= h0x;
            h1y    <= h0y;
            h0x    <= in_data.point_x;
            h0y    <= in_data.point_y;
            mstep  <= '0;
            state  <= (density == 16'd0) ? ST_ZERO : ST_MUL;
          end
        end
        ST_ZERO: begin
          if (slot_free) begin
            out_data.dot_x      <= h0x;
            out_data.dot_y      <= h0y;
            out_data.dot_weight <= {1'b0, brightness};
            out_data.last_dot   <= 1'b1;
            state               <= ST_IDLE;
          end
        end
        ST_MUL: begin
          mstep <= mstep + 3'd1;
          case (mstep)
            3'd1: sqx <= prod;
            3'd2: s61 <= (big || s_sum >= 64'h1000_0000_0000_0000) ?
                         61'h1000_0000_0000_0000 : s_sum[60:0];
            3'd3: d2  <= prod[31:0];
            3'd5: pl  <= prod[61:0];
            3'd6: begin
              ksq   <= 13'd1;
              k     <= 7'd1;
              n     <= 7'd1;
              state <= ST_CNT;
            end
            default: ;
          endcase
          if (mstep == 3'd6) begin
            // Keep the product-derived count threshold for the search.
            sqx <= {49'b0, pq};
          end
        end
        ST_CNT: begin
          if ((k <= lim) && ({2'b0, ksq} <= sqx[14:0])) begin
            n   <= k;
            k   <= k + 7'd1;
            ksq <= ksq + {5'b0, k, 1'b1};
          end else begin
            div_op  <= '0;
            div_run <= 1'b0;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (!div_run) begin
            div_run <= 1'b1;
            case (div_op)
              2'd0: div_neg <= 1'b0;
              2'd1: begin
                div_neg  <= dw[19];
                w1       <= w1c[17:0];
                prev_end <= w2c[17:0];
              end
              2'd2:    div_neg <= dx[32];
              default: div_neg <= dy[32];
            endcase
          end else if (div_rsp.done) begin
            div_run <= 1'b0;
            div_op  <= div_op + 2'd1;
            case (div_op)
              2'd0: wt <= scale ? q_fix[16:0] : brightness;
              2'd1: begin
                qw <= q_fix[17:0];
                rw <= r_fix;
              end
              2'd2: begin
                qx <= q_fix;
                rx <= r_fix;
              end
              default: begin
                qy    <= q_fix;
                ry    <= r_fix;
                accx  <= '0;
                accy  <= '0;
                accw  <= '0;
                arx   <= '0;
                ary   <= '0;
                arw   <= '0;
                idx   <= '0;
                state <= ST_EMIT;
              end
            endcase
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_data.dot_x      <= base_x + accx_n;
            out_data.dot_y      <= base_y + accy_n;
            out_data.dot_weight <= w1 + accw_n;
            out_data.last_dot   <= (idx == n - 7'd1);
            accx <= accx_n;
            accy <= accy_n;
            accw <= accw_n;
            arx  <= arx_n;
            ary  <= ary_n;
            arw  <= arw_n;
            idx  <= idx + 7'd1;
            if (idx == n - 7'd1) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
